### sv/pdsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdsc_pkg
// Shared types and constants of the PD steering controller.
// ----------------------------------------------------------------------------
package pdsc_pkg;

  localparam logic [2:0] REG_PROP_GAIN = 3'd0;
  localparam logic [2:0] REG_DERIV_GAIN = 3'd1;
  localparam logic [2:0] REG_FF_GAIN = 3'd2;
  localparam logic [2:0] REG_CORR_LIMIT = 3'd3;
  localparam logic [2:0] REG_FILTER_ALPHA = 3'd4;
  localparam logic [2:0] REG_STEP_LIMIT = 3'd5;

  localparam logic [15:0] ALPHA_MAX = 16'd64225;
  localparam logic [15:0] DT_MIN_US = 16'd1000;
  localparam logic [35:0] DIV_SCALE = 36'd256000000;
  localparam logic [60:0] PROD_LIM = 61'h1000_0000_0000_0000;
  localparam int unsigned DIV_STEPS = 44;

  typedef struct packed {
    logic               action;
    logic signed [15:0] error;
    logic        [15:0] dt_us;
    logic signed [15:0] speed;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] correction;
    logic               rejected;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] deriv_gain;
    logic signed [31:0] feedforward_gain;
    logic        [14:0] correction_limit;
    logic        [15:0] filter_alpha;
    logic        [14:0] step_limit;
  } cfg_t;

  // multiplier operand sets
  typedef enum logic [2:0] {
    SEL_N   = 3'd0,  // |de| * 256e6, dividend of the derivative
    SEL_FR  = 3'd1,  // alpha * old filter value
    SEL_RAW = 3'd2,  // (1 - alpha) * raw derivative
    SEL_P   = 3'd3,  // e * kp * 256
    SEL_D   = 3'd4,  // kd * d
    SEL_FF  = 3'd5,  // kff * d
    SEL_FS  = 3'd6   // (kff * d) * speed
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     check;
    logic     mul_start;
    mul_sel_t sel;
    logic     div_start;
    logic     filt;
    logic     sum;
    logic     finish;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic is_clear;
    logic reject;
    logic spd_pos;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

### sv/pd_steering_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pd_steering_controller_top
// PD steering controller with filtered derivative, feedforward, rate limiter.
// ----------------------------------------------------------------------------
// One item at a time. A clear or rejected tick (zero dt or zero correction
// limit) goes from ST_CHECK straight to ST_EMIT. A normal control tick runs the
// 44-step restoring divider for the derivative (error step * 256e6 / dt) and
// six or seven passes through the one shared 36x18 multiplier (the
// feedforward-by-speed pass runs only when speed is positive). The result sits
// in an output register, so the next item is taken while a finished beat still
// waits on out_stall. Registers are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block itself
// does not enforce; an unknown index is ignored.
// ----------------------------------------------------------------------------
module pd_steering_controller_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pdsc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pdsc_pkg::out_item_t      out_data
);
  import pdsc_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PROP_GAIN:    cfg.prop_gain        <= cfg_data;
        REG_DERIV_GAIN:   cfg.deriv_gain       <= cfg_data;
        REG_FF_GAIN:      cfg.feedforward_gain <= cfg_data;
        REG_CORR_LIMIT:   cfg.correction_limit <= cfg_data[14:0];
        REG_FILTER_ALPHA: cfg.filter_alpha     <= cfg_data[15:0];
        REG_STEP_LIMIT:   cfg.step_limit       <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  pdsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  pdsc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### sv/pdsc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdsc_ctrl
// Sequencer: walks one tick through multiplies, divide, filter and output.
// ----------------------------------------------------------------------------
module pdsc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output pdsc_pkg::dp_cmd_t      cmd,
  input  wire pdsc_pkg::dp_stat_t stat
);
  import pdsc_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CHECK  = 8'b0000_0010,
    ST_MUL    = 8'b0000_0100,
    ST_DIV    = 8'b0000_1000,
    ST_FILT   = 8'b0001_0000,
    ST_SUM    = 8'b0010_0000,
    ST_FINISH = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

  state_t   state, state_next;
  mul_sel_t sel, sel_next;
  logic     first;

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.sel    = sel;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (stat.is_clear || stat.reject) begin
          state_next = ST_EMIT;
        end else begin
          sel_next   = SEL_N;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_start = first;
        if (stat.mul_done) begin
          case (sel)
            SEL_N:   state_next = ST_DIV;
            SEL_FR:  sel_next = SEL_RAW;
            SEL_RAW: state_next = ST_FILT;
            SEL_P:   sel_next = SEL_D;
            SEL_D:   sel_next = SEL_FF;
            SEL_FF: begin
              if (stat.spd_pos) begin
                sel_next = SEL_FS;
              end else begin
                state_next = ST_SUM;
              end
            end
            default: state_next = ST_SUM;
          endcase
        end
      end
      ST_DIV: begin
        cmd.div_start = first;
        if (stat.div_done) begin
          sel_next   = SEL_FR;
          state_next = ST_MUL;
        end
      end
      ST_FILT: begin
        cmd.filt   = 1'b1;
        sel_next   = SEL_P;
        state_next = ST_MUL;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= SEL_N;
      first <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      // start pulse on the first cycle of each multiply or divide pass
      first <= (state_next != state) || (sel_next != sel);
    end
  end

endmodule
`default_nettype wire

### sv/pdsc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdsc_datapath
// Controller state, shared 36x18 multiplier, restoring divider, output beat.
// ----------------------------------------------------------------------------
module pdsc_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pdsc_pkg::cfg_t      cfg,
  input  wire pdsc_pkg::in_item_t  in_data,
  input  wire pdsc_pkg::dp_cmd_t   cmd,
  output pdsc_pkg::dp_stat_t       stat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pdsc_pkg::out_item_t      out_data
);
  import pdsc_pkg::*;

  // item and controller state
  in_item_t           itm;
  logic        [15:0] dtc;
  logic signed [15:0] last_err;
  logic signed [35:0] fr;
  logic signed [15:0] last_out;
  logic               seeded;

  // multiplier
  logic [71:0]  ma;
  logic [35:0]  mb;
  logic         mneg;
  mul_sel_t     msel;
  logic [2:0]   cnt;
  logic         mbusy;
  logic [53:0]  pp;
  logic [1:0]   pk;
  logic [107:0] acc;

  // divider
  logic [43:0] ndiv;
  logic        dneg;
  logic [60:0] rq;
  logic [5:0]  dcnt;
  logic        dbusy;

  logic signed [35:0] raw;
  logic signed [61:0] pf, pr, sp, sd, sf;
  logic        [60:0] ffm;
  logic               ffneg;
  logic signed [63:0] sum;
  logic signed [15:0] res_corr;
  logic               res_rej;

  // operand magnitudes
  logic signed [16:0] diff;
  logic        [15:0] diff_mag;
  logic        [15:0] err_mag;
  logic        [35:0] fr_mag, raw_mag;
  logic        [31:0] prop_mag, dg_mag, ff_mag;
  logic        [15:0] a_c;
  logic        [16:0] a_inv;
  logic        [71:0] op_a;
  logic        [35:0] op_b;
  logic               op_neg;

  always_comb begin
    diff     = {itm.error[15], itm.error} - {last_err[15], last_err};
    diff_mag = diff[16] ? 16'(-diff) : diff[15:0];
    err_mag  = itm.error[15] ? 16'(-itm.error) : itm.error;
    fr_mag   = fr[35] ? 36'(-fr) : fr;
    raw_mag  = raw[35] ? 36'(-raw) : raw;
    prop_mag = cfg.prop_gain[31] ? 32'(-cfg.prop_gain) : cfg.prop_gain;
    dg_mag   = cfg.deriv_gain[31] ? 32'(-cfg.deriv_gain) : cfg.deriv_gain;
    ff_mag   = cfg.feedforward_gain[31] ? 32'(-cfg.feedforward_gain) : cfg.feedforward_gain;
    a_c      = (cfg.filter_alpha > ALPHA_MAX) ? ALPHA_MAX : cfg.filter_alpha;
    a_inv    = 17'h10000 - {1'b0, a_c};
  end

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    case (cmd.sel)
      SEL_N: begin
        op_a = 72'(diff_mag);  op_b = DIV_SCALE;       op_neg = diff[16];
      end
      SEL_FR: begin
        op_a = 72'(fr_mag);    op_b = 36'(a_c);        op_neg = fr[35];
      end
      SEL_RAW: begin
        op_a = 72'(raw_mag);   op_b = 36'(a_inv);      op_neg = raw[35];
      end
      SEL_P: begin
        op_a   = 72'({err_mag, 8'h00});
        op_b   = 36'(prop_mag);
        op_neg = itm.error[15] ^ cfg.prop_gain[31];
      end
      SEL_D: begin
        op_a = 72'(fr_mag);    op_b = 36'(dg_mag);
        op_neg = fr[35] ^ cfg.deriv_gain[31];
      end
      SEL_FF: begin
        op_a = 72'(fr_mag);    op_b = 36'(ff_mag);
        op_neg = fr[35] ^ cfg.feedforward_gain[31];
      end
      SEL_FS: begin
        op_a = 72'(ffm);       op_b = 36'(itm.speed[14:0]); op_neg = ffneg;
      end
      default: ;
    endcase
  end

  // partial product chunk and its place in the accumulator
  logic [35:0]  a_chunk;
  logic [17:0]  b_chunk;
  logic [107:0] pp_sh;
  logic [60:0]  pm;
  logic signed [61:0] pval;

  always_comb begin
    a_chunk = cnt[1] ? ma[71:36] : ma[35:0];
    b_chunk = cnt[0] ? mb[35:18] : mb[17:0];
    case (pk)
      2'd0:    pp_sh = 108'(pp);
      2'd1:    pp_sh = 108'(pp) << 18;
      2'd2:    pp_sh = 108'(pp) << 36;
      default: pp_sh = 108'(pp) << 54;
    endcase
    // magnitude saturates at 2^60
    pm   = (acc > 108'(PROD_LIM)) ? PROD_LIM : acc[60:0];
    pval = mneg ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
  end

  // filter: d = trunc0((pf + pr) / 2^16)
  logic signed [61:0] fsum;
  logic        [61:0] fmag;
  logic        [45:0] fq;
  logic signed [35:0] d_new;

  always_comb begin
    fsum  = pf + pr;
    fmag  = fsum[61] ? 62'(-fsum) : fsum;
    fq    = fmag[61:16];
    d_new = fsum[61] ? 36'(-fq) : 36'(fq);
  end

  // output stage: truncate, clamp, step-limit, clamp again
  logic        [63:0] smag;
  logic        [31:0] sq;
  logic        [14:0] qc;
  logic signed [17:0] corr, delta, step, lo_ext, lim_ext, newo, fin;

  always_comb begin
    smag    = sum[63] ? 64'(-sum) : sum;
    sq      = smag[63:32];
    qc      = (sq > 32'(cfg.correction_limit)) ? cfg.correction_limit : sq[14:0];
    corr    = sum[63] ? -$signed({3'b000, qc}) : $signed({3'b000, qc});
    lo_ext  = 18'(last_out);
    step    = $signed({3'b000, cfg.step_limit});
    lim_ext = $signed({3'b000, cfg.correction_limit});
    delta   = corr - lo_ext;
    if ((step != 18'sd0) && (delta > step)) begin
      newo = lo_ext + step;
    end else if ((step != 18'sd0) && (delta < -step)) begin
      newo = lo_ext - step;
    end else begin
      newo = corr;
    end
    if (newo > lim_ext) begin
      fin = lim_ext;
    end else if (newo < -lim_ext) begin
      fin = -lim_ext;
    end else begin
      fin = newo;
    end
  end

  always_comb begin
    stat.mul_done = mbusy && (cnt == 3'd5);
    stat.div_done = dbusy && (dcnt == 6'd0);
    stat.is_clear = itm.action;
    stat.reject   = (itm.dt_us == 16'd0) || (cfg.correction_limit == 15'd0);
    stat.spd_pos  = !itm.speed[15] && (itm.speed != 16'sd0);
    stat.out_free = !out_valid || !out_stall;
  end

  // divider step: shift one dividend bit into the remainder
  logic [16:0] trial;
  logic        fits;

  always_comb begin
    trial = {rq[59:44], rq[43]};
    fits  = trial >= {1'b0, dtc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded    <= 1'b0;
      last_err  <= '0;
      fr        <= '0;
      last_out  <= '0;
      mbusy     <= 1'b0;
      dbusy     <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
      dcnt      <= '0;
    end else begin
      if (cmd.load) begin
        itm <= in_data;
        dtc <= (in_data.dt_us < DT_MIN_US) ? DT_MIN_US : in_data.dt_us;
      end

      if (cmd.check) begin
        res_corr <= '0;
        res_rej  <= 1'b1;
        if (itm.action) begin
          seeded   <= 1'b0;
          last_err <= '0;
          fr       <= '0;
          last_out <= '0;
        end else if (!stat.reject && !seeded) begin
          seeded   <= 1'b1;
          last_err <= itm.error;
          fr       <= '0;
          last_out <= '0;
        end
      end

      // shared multiplier: four chunk products, each registered in pp before it is added into acc
      if (cmd.mul_start) begin
        ma    <= op_a;
        mb    <= op_b;
        mneg  <= op_neg;
        msel  <= cmd.sel;
        cnt   <= '0;
        acc   <= '0;
        mbusy <= 1'b1;
      end else if (mbusy) begin
        if (cnt <= 3'd3) begin
          pp <= a_chunk * b_chunk;
          pk <= cnt[1:0];
        end
        if ((cnt >= 3'd1) && (cnt <= 3'd4)) begin
          acc <= acc + pp_sh;
        end
        if (cnt == 3'd5) begin
          mbusy <= 1'b0;
          case (msel)
            SEL_N: begin
              ndiv <= pm[43:0];
              dneg <= mneg;
            end
            SEL_FR:  pf <= pval;
            SEL_RAW: pr <= pval;
            SEL_P:   sp <= pval;
            SEL_D:   sd <= pval;
            SEL_FF: begin
              ffm   <= pm;
              ffneg <= mneg;
              sf    <= '0;
            end
            default: sf <= pval;
          endcase
        end else begin
          cnt <= cnt + 3'd1;
        end
      end

      // restoring divide, one quotient bit per cycle
      if (cmd.div_start) begin
        rq    <= {17'd0, ndiv};
        dcnt  <= 6'(DIV_STEPS);
        dbusy <= 1'b1;
      end else if (dbusy) begin
        if (dcnt == 6'd0) begin
          dbusy <= 1'b0;
          raw   <= dneg ? 36'(-$signed({1'b0, rq[34:0]})) : $signed({1'b0, rq[34:0]});
        end else begin
          rq   <= {fits ? (trial - {1'b0, dtc}) : trial, rq[42:0], fits};
          dcnt <= dcnt - 6'd1;
        end
      end

      if (cmd.filt) begin
        fr <= d_new;
      end

      if (cmd.sum) begin
        sum <= 64'(sp) + 64'(sd) + 64'(sf);
      end

      if (cmd.finish) begin
        last_err <= itm.error;
        last_out <= newo[15:0];
        res_corr <= fin[15:0];
        res_rej  <= 1'b0;
      end

      if (cmd.emit) begin
        out_valid           <= 1'b1;
        out_data.correction <= res_corr;
        out_data.rejected   <= res_rej;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
